// File: rtl/rrsa_pkg.sv
`default_nettype none

package rrsa_pkg;

  // Result status codes
  typedef enum logic [1:0] {
    STATUS_GRANTED   = 2'd0,
    STATUS_TOO_LARGE = 2'd1,
    STATUS_NO_MEMORY = 2'd2,
    STATUS_FREED     = 2'd3
  } status_e;

  // Request action codes
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  // Configuration register map
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_SLOTS  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_BYTES = 1'd1;

  localparam int unsigned POOL_W  = 7;
  localparam int unsigned CHUNK_W = 8;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned COUNT_W = 8;
  localparam int unsigned SIZE_W  = 8;
  localparam int unsigned INDEX_W = 6;

  localparam logic [POOL_W-1:0]  POOL_RESET  = 7'd32;
  localparam logic [CHUNK_W-1:0] CHUNK_RESET = 8'd128;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_MOD,
    S_SEARCH,
    S_DONE
  } state_e;

endpackage

`default_nettype wire

// File: rtl/round_robin_slot_allocator_unit.sv
`default_nettype none

// Next-fit slot allocator for a pool of up to MAX_SLOTS equal-sized slots.
// One in-use flag per slot lives in a single-port-write, registered-read
// memory; a search head remembers where the last grant ended. An allocate
// request first checks request_count * request_size against chunk_bytes
// (status too large), then scans the flags one per cycle from the head
// (wrapping at the pool size), marks the first free slot and returns it, or
// answers out of memory after visiting every slot. A free request clears
// the flag of the named slot; indexes at or above the pool size are ignored.
// Operation: after reset the flag memory is cleared slot by slot over all
// MAX_SLOTS slots, during which no request is taken (configuration writes
// are always taken). A free, a too-large or an empty-pool request passes
// from acceptance through the decode state and the done state into the
// output register once that register is free. An allocate that searches
// also reduces the head modulo the pool size one bit per cycle, then scans
// 1 to pool size slots, bound by the one flag read per cycle of the memory
// port. One request is handled at a time; a new request is accepted while
// the previous result still waits in the output register.
// Configure only while idle.
module round_robin_slot_allocator_unit #(
  parameter int unsigned MAX_SLOTS = 64
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  // configuration write channel
  input  wire                                cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire  [rrsa_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire  [rrsa_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  // request channel
  input  wire                                in_valid_i,
  output logic                               in_ready_o,
  input  wire                                action_i,
  input  wire  [rrsa_pkg::COUNT_W-1:0]       request_count_i,
  input  wire  [rrsa_pkg::SIZE_W-1:0]        request_size_i,
  input  wire  [rrsa_pkg::INDEX_W-1:0]       slot_index_i,
  // result channel
  output logic                               out_valid_o,
  input  wire                                out_ready_i,
  output rrsa_pkg::status_e                  status_o,
  output logic [rrsa_pkg::INDEX_W-1:0]       granted_slot_o
);
  import rrsa_pkg::*;

  // HW: slot address width, NW: width of a slot count up to MAX_SLOTS
  localparam int unsigned HW  = $clog2(MAX_SLOTS);
  localparam int unsigned NW  = $clog2(MAX_SLOTS + 1);
  localparam int unsigned CW  = (NW > POOL_W) ? NW : POOL_W;
  localparam int unsigned XW  = (NW > INDEX_W) ? NW : INDEX_W;
  localparam int unsigned SCW = $clog2(HW + 1);
  localparam int unsigned PW  = COUNT_W + SIZE_W;

  // Configuration registers
  logic [POOL_W-1:0]  pool_slots_q;
  logic [CHUNK_W-1:0] chunk_bytes_q;

  // Control state
  state_e         state_q, state_d;
  logic [HW-1:0]  head_q, head_d;
  logic [HW-1:0]  rd_addr_q, rd_addr_d;   // scan read address, also clear pointer
  logic [HW-1:0]  chk_addr_q, chk_addr_d; // address of the flag now in rd_flag_q
  logic           chk_vld_q, chk_vld_d;
  logic [NW-1:0]  chk_cnt_q, chk_cnt_d;
  logic [NW-1:0]  rem_q, rem_d;
  logic [HW-1:0]  quo_q, quo_d;
  logic [SCW-1:0] step_q, step_d;
  logic           out_valid_q, out_valid_d;

  // Request and result payload
  logic                 req_action_q;
  logic [COUNT_W-1:0]   req_count_q;
  logic [SIZE_W-1:0]    req_size_q;
  logic [INDEX_W-1:0]   req_index_q;
  status_e              res_status_q, res_status_d;
  logic [INDEX_W-1:0]   res_slot_q, res_slot_d;
  status_e              out_status_q;
  logic [INDEX_W-1:0]   out_slot_q;

  // Flag memory
  logic           slot_mem_q [MAX_SLOTS];
  logic           rd_flag_q;
  logic           mem_we;
  logic [HW-1:0]  mem_waddr;
  logic           mem_wdata;

  logic           in_fire;
  logic           out_load;
  logic [CW-1:0]  pool_ext;
  logic [NW-1:0]  n_eff;
  logic [PW-1:0]  product;
  logic [XW-1:0]  idx_x;
  logic [XW-1:0]  grant_x;
  logic [NW:0]    rem_sh;
  logic [NW:0]    rem_nx;
  logic [NW-1:0]  rd_next;
  logic [NW-1:0]  chk_next;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i & in_ready_o;

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign granted_slot_o = out_slot_q;

  // Effective pool size saturates at MAX_SLOTS
  assign pool_ext = CW'(pool_slots_q);
  assign n_eff    = (pool_ext > CW'(MAX_SLOTS)) ? NW'(MAX_SLOTS) : NW'(pool_ext);

  assign product = PW'(req_count_q) * PW'(req_size_q);
  assign idx_x   = XW'(req_index_q);
  assign grant_x = XW'(chk_addr_q);

  // One restoring step of head modulo pool size
  assign rem_sh = {rem_q, quo_q[HW-1]};
  assign rem_nx = (rem_sh >= {1'b0, n_eff}) ? (rem_sh - {1'b0, n_eff}) : rem_sh;

  // Wrapped successors of the scan and check addresses
  assign rd_next  = (NW'(rd_addr_q) + NW'(1) == n_eff) ? '0 : NW'(rd_addr_q) + NW'(1);
  assign chk_next = (NW'(chk_addr_q) + NW'(1) == n_eff) ? '0 : NW'(chk_addr_q) + NW'(1);

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_slots_q  <= POOL_RESET;
      chunk_bytes_q <= CHUNK_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_POOL_SLOTS:  pool_slots_q  <= cfg_data_i[POOL_W-1:0];
        CFG_CHUNK_BYTES: chunk_bytes_q <= cfg_data_i[CHUNK_W-1:0];
        default: ;
      endcase
    end
  end

  // Flag memory: one write port, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      slot_mem_q[mem_waddr] <= mem_wdata;
    end
    rd_flag_q <= slot_mem_q[rd_addr_q];
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      head_q      <= '0;
      rd_addr_q   <= '0;
      chk_addr_q  <= '0;
      chk_vld_q   <= 1'b0;
      chk_cnt_q   <= '0;
      rem_q       <= '0;
      quo_q       <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      rd_addr_q   <= rd_addr_d;
      chk_addr_q  <= chk_addr_d;
      chk_vld_q   <= chk_vld_d;
      chk_cnt_q   <= chk_cnt_d;
      rem_q       <= rem_d;
      quo_q       <= quo_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_action_q <= action_i;
      req_count_q  <= request_count_i;
      req_size_q   <= request_size_i;
      req_index_q  <= slot_index_i;
    end
    res_status_q <= res_status_d;
    res_slot_q   <= res_slot_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_slot_q   <= res_slot_q;
    end
  end

  // Next state and datapath control
  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    rd_addr_d    = rd_addr_q;
    chk_addr_d   = chk_addr_q;
    chk_vld_d    = chk_vld_q;
    chk_cnt_d    = chk_cnt_q;
    rem_d        = rem_q;
    quo_d        = quo_q;
    step_d       = step_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    mem_we       = 1'b0;
    mem_waddr    = rd_addr_q;
    mem_wdata    = 1'b0;
    out_load     = 1'b0;

    unique case (state_q)
      S_CLEAR: begin
        // Sweep every flag to free after reset
        mem_we    = 1'b1;
        mem_waddr = rd_addr_q;
        if (rd_addr_q == HW'(MAX_SLOTS - 1)) begin
          rd_addr_d = '0;
          state_d   = S_IDLE;
        end else begin
          rd_addr_d = rd_addr_q + HW'(1);
        end
      end

      S_IDLE: begin
        if (in_fire) begin
          state_d = S_DECODE;
        end
      end

      S_DECODE: begin
        res_slot_d = '0;
        state_d    = S_DONE;
        if (req_action_q == ACT_FREE) begin
          // Release the slot if it lies inside the pool
          if (idx_x < XW'(n_eff)) begin
            mem_we    = 1'b1;
            mem_waddr = idx_x[HW-1:0];
            mem_wdata = 1'b0;
          end
          res_status_d = STATUS_FREED;
        end else if (product > PW'(chunk_bytes_q)) begin
          res_status_d = STATUS_TOO_LARGE;
        end else if (n_eff == '0) begin
          res_status_d = STATUS_NO_MEMORY;
        end else begin
          // Reduce the head modulo the pool size before scanning
          rem_d   = '0;
          quo_d   = head_q;
          step_d  = SCW'(HW);
          state_d = S_MOD;
        end
      end

      S_MOD: begin
        rem_d  = rem_nx[NW-1:0];
        quo_d  = quo_q << 1;
        step_d = step_q - SCW'(1);
        if (step_q == SCW'(1)) begin
          rd_addr_d = rem_nx[HW-1:0];
          chk_vld_d = 1'b0;
          chk_cnt_d = '0;
          state_d   = S_SEARCH;
        end
      end

      S_SEARCH: begin
        // Issue one flag read per cycle, check the one read last cycle
        rd_addr_d  = rd_next[HW-1:0];
        chk_addr_d = rd_addr_q;
        chk_vld_d  = 1'b1;
        if (chk_vld_q) begin
          if (!rd_flag_q) begin
            mem_we       = 1'b1;
            mem_waddr    = chk_addr_q;
            mem_wdata    = 1'b1;
            head_d       = chk_next[HW-1:0];
            res_status_d = STATUS_GRANTED;
            res_slot_d   = grant_x[INDEX_W-1:0];
            chk_vld_d    = 1'b0;
            state_d      = S_DONE;
          end else if (chk_cnt_q + NW'(1) == n_eff) begin
            // Every slot visited and busy: head stays put
            res_status_d = STATUS_NO_MEMORY;
            res_slot_d   = '0;
            chk_vld_d    = 1'b0;
            state_d      = S_DONE;
          end else begin
            chk_cnt_d = chk_cnt_q + NW'(1);
          end
        end
      end

      S_DONE: begin
        // Hand the result over once the output register is free
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    out_valid_d = (out_valid_q && !out_ready_i) || out_load;
  end

endmodule

`default_nettype wire
